### rtl/core/tccw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console character writer package
// Shared constants, result kind codes and the command and status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tccw_pkg;

    // Screen geometry defaults.
    localparam int SCREEN_COLUMNS_DEF = 80;
    localparam int SCREEN_ROWS_DEF    = 25;
    localparam int TAB_STOP_DEF       = 4;

    // Fixed field widths of the ports.
    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int KIND_W      = 2;
    localparam int CELL_ADDR_W = 11;
    localparam int CELL_VAL_W  = 16;
    localparam int ROW_OUT_W   = 5;
    localparam int COL_OUT_W   = 7;

    // Attribute after reset, and the special bytes.
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0c;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;

    // Kind of one result beat.
    typedef enum logic [KIND_W-1:0] {
        KIND_CELL   = 2'd0,
        KIND_SCROLL = 2'd1,
        KIND_CURSOR = 2'd2
    } result_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;       // capture the input beat, apply newline or return
        logic emit_cell;    // load a cell write and advance the cursor
        logic emit_scroll;  // load a scroll request and pin the row
        logic emit_cursor;  // load a cursor update
        logic last;         // last result of this input
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_lf;     // incoming byte is a newline
        logic in_is_cr;     // incoming byte is a carriage return
        logic cell_done;    // the cell about to be written ends the run of cells
        logic cell_scroll;  // the cell about to be written wraps past the bottom
        logic row_over;     // the row sits past the last line
        logic eos;          // the held byte ends the string
        logic slot_free;    // the output register can take a beat
    } sts_t;

endpackage

`default_nettype wire

### rtl/core/tccw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer controller
// Sequences the results of one byte: cell writes, then a scroll request,
// then a cursor update, each loaded only when the output register is free.
// ----------------------------------------------------------------------------
module tccw_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  tccw_pkg::sts_t      sts,
    output tccw_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CELL   = 4'b0010,
        ST_SCROLL = 4'b0100,
        ST_CURSOR = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        in_ready        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    if (sts.in_is_lf || sts.in_is_cr)
                    begin
                        state_next = ST_SCROLL;
                    end
                    else
                    begin
                        state_next = ST_CELL;
                    end
                end
            end
            ST_CELL:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_cell = 1'b1;
                    cmd.last      = sts.cell_done && !sts.cell_scroll && !sts.eos;
                    if (sts.cell_done)
                    begin
                        state_next = ST_SCROLL;
                    end
                end
            end
            ST_SCROLL:
            begin
                // A scroll request waits for a free slot; otherwise move on at once.
                if (!sts.row_over || sts.slot_free)
                begin
                    cmd.emit_scroll = sts.row_over;
                    cmd.last        = !sts.eos;
                    state_next      = sts.eos ? ST_CURSOR : ST_IDLE;
                end
            end
            ST_CURSOR:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit_cursor = 1'b1;
                    cmd.last        = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/tccw_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console writer datapath
// Holds the cursor, the tab phase, the attribute register, the captured
// input byte and the output register.
// ----------------------------------------------------------------------------
module tccw_datapath #(
    parameter int SCREEN_COLUMNS = tccw_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tccw_pkg::SCREEN_ROWS_DEF,
    parameter int TAB_STOP       = tccw_pkg::TAB_STOP_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [tccw_pkg::ATTR_W-1:0]      cfg_wdata,
    input  wire logic [tccw_pkg::CHAR_W-1:0]      character,
    input  wire logic                             end_of_string,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [tccw_pkg::KIND_W-1:0]           result_kind,
    output logic [tccw_pkg::CELL_ADDR_W-1:0]      cell_address,
    output logic [tccw_pkg::CELL_VAL_W-1:0]       cell_value,
    output logic [tccw_pkg::ROW_OUT_W-1:0]        cursor_row_out,
    output logic [tccw_pkg::COL_OUT_W-1:0]        cursor_col_out,
    output logic                                  last_of_run,
    input  tccw_pkg::cmd_t                        cmd,
    output tccw_pkg::sts_t                        sts
);

    // The row may briefly hold SCREEN_ROWS before a scroll pins it.
    localparam int ROW_W  = $clog2(SCREEN_ROWS + 1);
    localparam int COL_W  = $clog2(SCREEN_COLUMNS);
    localparam int PH_W   = $clog2(TAB_STOP);
    localparam int FULL_W = ROW_W + COL_W;
    localparam int AW     = tccw_pkg::CELL_ADDR_W;
    localparam int RW     = tccw_pkg::ROW_OUT_W;
    localparam int CW     = tccw_pkg::COL_OUT_W;

    logic [ROW_W-1:0]              row_reg;
    logic [ROW_W-1:0]              row_next;
    logic [COL_W-1:0]              col_reg;
    logic [COL_W-1:0]              col_next;
    logic [PH_W-1:0]               phase_reg;
    logic [PH_W-1:0]               phase_next;
    logic [tccw_pkg::ATTR_W-1:0]   attr_reg;
    logic [tccw_pkg::CHAR_W-1:0]   char_reg;
    logic                          eos_reg;
    logic                          tab_reg;

    logic                          out_valid_reg;
    tccw_pkg::result_kind_t        kind_reg;
    logic [AW-1:0]                 addr_reg;
    logic [tccw_pkg::CELL_VAL_W-1:0] value_reg;
    logic [RW-1:0]                 orow_reg;
    logic [CW-1:0]                 ocol_reg;
    logic                          olast_reg;

    logic                          col_wrap;
    logic                          phase_last;
    logic [FULL_W-1:0]             addr_full;
    logic [tccw_pkg::CHAR_W-1:0]   cell_char;
    logic                          any_emit;

    // Cursor conditions of the cell about to be written.
    assign col_wrap   = (col_reg == COL_W'(SCREEN_COLUMNS - 1));
    assign phase_last = (phase_reg == PH_W'(TAB_STOP - 1));
    assign addr_full  = FULL_W'(row_reg) * FULL_W'(SCREEN_COLUMNS) + FULL_W'(col_reg);
    assign cell_char  = tab_reg ? tccw_pkg::CHAR_BLANK : char_reg;
    assign any_emit   = cmd.emit_cell || cmd.emit_scroll || cmd.emit_cursor;

    // Status toward the controller.
    always_comb
    begin
        sts.in_is_lf    = (character == tccw_pkg::CHAR_LF);
        sts.in_is_cr    = (character == tccw_pkg::CHAR_CR);
        sts.cell_done   = !tab_reg || col_wrap || phase_last;
        sts.cell_scroll = col_wrap && (row_reg == ROW_W'(SCREEN_ROWS - 1));
        sts.row_over    = (row_reg >= ROW_W'(SCREEN_ROWS));
        sts.eos         = eos_reg;
        sts.slot_free   = !out_valid_reg || out_ready;
    end

    // Cursor and tab phase updates.
    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        phase_next = phase_reg;
        priority if (cmd.accept && sts.in_is_lf)
        begin
            row_next   = row_reg + 1'b1;
            col_next   = '0;
            phase_next = '0;
        end
        else if (cmd.accept && sts.in_is_cr)
        begin
            col_next   = '0;
            phase_next = '0;
        end
        else if (cmd.emit_cell)
        begin
            if (col_wrap)
            begin
                row_next   = row_reg + 1'b1;
                col_next   = '0;
                phase_next = '0;
            end
            else
            begin
                col_next   = col_reg + 1'b1;
                phase_next = phase_last ? '0 : phase_reg + 1'b1;
            end
        end
        else if (cmd.emit_scroll)
        begin
            row_next = ROW_W'(SCREEN_ROWS - 1);
        end
    end

    // Control registers: cursor, phase, attribute and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            phase_reg     <= '0;
            attr_reg      <= tccw_pkg::ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            phase_reg <= phase_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
            if (any_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Captured input byte.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            char_reg <= character;
            eos_reg  <= end_of_string;
            tab_reg  <= (character == tccw_pkg::CHAR_TAB);
        end
    end

    // Output register payload; unused fields are zero.
    always_ff @(posedge clk)
    begin
        if (any_emit)
        begin
            olast_reg <= cmd.last;
            addr_reg  <= '0;
            value_reg <= '0;
            orow_reg  <= '0;
            ocol_reg  <= '0;
            priority if (cmd.emit_cell)
            begin
                kind_reg  <= tccw_pkg::KIND_CELL;
                addr_reg  <= AW'(addr_full);
                value_reg <= {attr_reg, cell_char};
            end
            else if (cmd.emit_scroll)
            begin
                kind_reg <= tccw_pkg::KIND_SCROLL;
            end
            else
            begin
                kind_reg <= tccw_pkg::KIND_CURSOR;
                orow_reg <= RW'(row_reg);
                ocol_reg <= CW'(col_reg);
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = kind_reg;
    assign cell_address   = addr_reg;
    assign cell_value     = value_reg;
    assign cursor_row_out = orow_reg;
    assign cursor_col_out = ocol_reg;
    assign last_of_run    = olast_reg;

endmodule

`default_nettype wire

### rtl/core/text_console_char_writer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text console character writer
// Turns a string, one byte per beat, into cell writes, scroll requests and
// cursor updates for a character screen, keeping the cursor row and column.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  in      | sink      | in_valid / in_ready  | character, end_of_string
//  out     | source    | out_valid/out_ready  | result_kind .. last_of_run
//  cfg     | sink      | cfg_we               | cfg_wdata (text attribute)
//
//  One byte is taken at a time. A newline or return goes from idle to scroll,
//  a plain byte from idle through cell to scroll; each tab blank past the
//  first is one more cell write, and a cursor update adds the cursor state.
//  A scroll request goes out in the closing scroll state that every byte has.
//  The controller loads one result per cycle into the single output register;
//  a stalled output holds the controller. Reset puts the cursor at row 0,
//  column 0 and the attribute at 0x0c.
// ----------------------------------------------------------------------------
module text_console_char_writer_core #(
    parameter int SCREEN_COLUMNS = tccw_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tccw_pkg::SCREEN_ROWS_DEF,
    parameter int TAB_STOP       = tccw_pkg::TAB_STOP_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [tccw_pkg::ATTR_W-1:0]      cfg_wdata,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [tccw_pkg::CHAR_W-1:0]      character,
    input  wire logic                             end_of_string,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [tccw_pkg::KIND_W-1:0]           result_kind,
    output logic [tccw_pkg::CELL_ADDR_W-1:0]      cell_address,
    output logic [tccw_pkg::CELL_VAL_W-1:0]       cell_value,
    output logic [tccw_pkg::ROW_OUT_W-1:0]        cursor_row_out,
    output logic [tccw_pkg::COL_OUT_W-1:0]        cursor_col_out,
    output logic                                  last_of_run
);

    tccw_pkg::cmd_t cmd;
    tccw_pkg::sts_t sts;

    // Controller.
    tccw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath.
    tccw_datapath #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .TAB_STOP       (TAB_STOP)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .character      (character),
        .end_of_string  (end_of_string),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_kind    (result_kind),
        .cell_address   (cell_address),
        .cell_value     (cell_value),
        .cursor_row_out (cursor_row_out),
        .cursor_col_out (cursor_col_out),
        .last_of_run    (last_of_run),
        .cmd            (cmd),
        .sts            (sts)
    );

`ifndef SYNTHESIS
    // Only one byte is in work at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a byte is still in work");

    // A cursor update always closes the run of results.
    a_cursor_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == tccw_pkg::KIND_CURSOR) |-> last_of_run)
        else $error("cursor update not marked last");

    // A reported cursor row is always on the screen.
    a_cursor_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == tccw_pkg::KIND_CURSOR)
            |-> (int'(cursor_row_out) < SCREEN_ROWS))
        else $error("cursor row reported past the last line");

    // No new byte is taken while the previous run has not closed.
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_run) |-> !in_ready)
        else $error("input ready in the middle of a run");
`endif

endmodule

`default_nettype wire
